### src/gps_pkg.sv
// shared types, constants and move tables for the grid path search block
`timescale 1ns / 1ps
package gps_pkg;

  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 32;

  localparam int COORD_W  = 5;
  localparam int ACT_W    = 2;
  localparam int STEP_W   = 10;
  localparam int LEN_W    = 11;
  localparam int SCORE_W  = 18;
  localparam int COST_W   = 8;
  localparam int DIR_W    = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [COST_W-1:0]  STRAIGHT_COST_RST = 8'd70;
  localparam logic [COST_W-1:0]  DIAGONAL_COST_RST = 8'd99;
  localparam logic [SCORE_W-1:0] SCORE_MAX         = '1;

  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  // x step of a move direction: four straight moves, then four diagonals
  function automatic logic signed [1:0] move_dx(input logic [DIR_W-1:0] dir);
    logic signed [1:0] d;
    unique case (dir)
      3'd0, 3'd2: d = 2'sd0;
      3'd1, 3'd4, 3'd6: d = 2'sd1;
      default: d = -2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] move_dy(input logic [DIR_W-1:0] dir);
    logic signed [1:0] d;
    unique case (dir)
      3'd1, 3'd3: d = 2'sd0;
      3'd0, 3'd4, 3'd5: d = 2'sd1;
      default: d = -2'sd1;
    endcase
    return d;
  endfunction

  // straight direction that flanks a diagonal along x
  function automatic logic [1:0] flank_x(input logic [DIR_W-1:0] dir);
    logic [1:0] f;
    f = (move_dx(dir) == 2'sd1) ? 2'd1 : 2'd3;
    return f;
  endfunction

  // straight direction that flanks a diagonal along y
  function automatic logic [1:0] flank_y(input logic [DIR_W-1:0] dir);
    logic [1:0] f;
    f = (move_dy(dir) == 2'sd1) ? 2'd0 : 2'd2;
    return f;
  endfunction

  typedef struct packed {
    logic accept;
    logic load_write;
    logic search_init;
    logic sweep_init;
    logic sweep_seen;
    logic seed;
    logic pop;
    logic cur_take;
    logic score_take;
    logic probe_issue;
    logic probe_commit;
    logic trace_issue;
    logic trace_step;
    logic trace_ok;
    logic read_issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    ends_ok;
    logic    read_hit;
    logic    sweep_last;
    logic    q_empty;
    logic    cur_goal;
    logic    probe_skip;
    logic    dir_last;
    logic    at_start;
    logic    k_full;
    logic    parent_bad;
    logic    out_free;
  } status_t;

endpackage

### src/gps_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module gps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/gps_ctrl.sv
// sequencing state machine of the grid path search
`timescale 1ns / 1ps
module gps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gps_pkg::status_t st_i,
  output gps_pkg::cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_INIT     = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_DISPATCH = 13'b0000000000100,
    S_CLEAR    = 13'b0000000001000,
    S_SEED     = 13'b0000000010000,
    S_POP      = 13'b0000000100000,
    S_CUR      = 13'b0000001000000,
    S_SCORE    = 13'b0000010000000,
    S_PROBE    = 13'b0000100000000,
    S_DECIDE   = 13'b0001000000000,
    S_TRACE_A  = 13'b0010000000000,
    S_TRACE_B  = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_init = 1'b1;
        if (st_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st_i.action)
          gps_pkg::ACT_LOAD: begin
            cmd_o.load_write = 1'b1;
            state_d          = S_DONE;
          end
          gps_pkg::ACT_SEARCH: begin
            cmd_o.search_init = 1'b1;
            state_d           = st_i.ends_ok ? S_CLEAR : S_DONE;
          end
          gps_pkg::ACT_READ: begin
            cmd_o.read_issue = st_i.read_hit;
            state_d          = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_CLEAR: begin
        cmd_o.sweep_seen = 1'b1;
        if (st_i.sweep_last) state_d = S_SEED;
      end
      S_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = S_POP;
      end
      S_POP: begin
        if (st_i.q_empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_CUR;
        end
      end
      S_CUR: begin
        cmd_o.cur_take = 1'b1;
        state_d        = st_i.cur_goal ? S_TRACE_A : S_SCORE;
      end
      S_SCORE: begin
        cmd_o.score_take = 1'b1;
        state_d          = S_PROBE;
      end
      S_PROBE: begin
        cmd_o.probe_issue = 1'b1;
        if (st_i.probe_skip) begin
          state_d = st_i.dir_last ? S_POP : S_PROBE;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.probe_commit = 1'b1;
        state_d            = st_i.dir_last ? S_POP : S_PROBE;
      end
      S_TRACE_A: begin
        priority if (st_i.at_start) begin
          cmd_o.trace_ok = 1'b1;
          state_d        = S_DONE;
        end else if (st_i.k_full) begin
          state_d = S_DONE;
        end else begin
          cmd_o.trace_issue = 1'b1;
          state_d           = S_TRACE_B;
        end
      end
      S_TRACE_B: begin
        if (st_i.parent_bad) begin
          state_d = S_DONE;
        end else begin
          cmd_o.trace_step = 1'b1;
          state_d          = S_TRACE_A;
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/gps_datapath.sv
// memories, counters and decision logic of the grid path search
`timescale 1ns / 1ps
module gps_datapath #(
  parameter int GRID_WIDTH  = gps_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gps_pkg::GRID_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gps_pkg::cmd_t                     cmd_i,
  output gps_pkg::status_t                  st_o,
  input  logic [gps_pkg::ACT_W-1:0]         action_i,
  input  logic [gps_pkg::COORD_W-1:0]       pos_x_i,
  input  logic [gps_pkg::COORD_W-1:0]       pos_y_i,
  input  logic                              passable_i,
  input  logic [gps_pkg::COORD_W-1:0]       goal_x_i,
  input  logic [gps_pkg::COORD_W-1:0]       goal_y_i,
  input  logic [gps_pkg::STEP_W-1:0]        step_index_i,
  input  logic                              cfg_we_i,
  input  logic [gps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gps_pkg::COST_W-1:0]        cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              found_o,
  output logic [gps_pkg::LEN_W-1:0]         path_length_o,
  output logic [gps_pkg::SCORE_W-1:0]       goal_score_o,
  output logic                              step_valid_o,
  output logic [gps_pkg::COORD_W-1:0]       step_x_o,
  output logic [gps_pkg::COORD_W-1:0]       step_y_o
);

  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int CW    = AW + 1;
  localparam int SW    = gps_pkg::SCORE_W;
  localparam int DW    = gps_pkg::DIR_W;

  // captured item
  gps_pkg::action_e                act_q;
  logic [gps_pkg::COORD_W-1:0]     px_q, py_q, gx_q, gy_q;
  logic                            pass_q;
  logic [gps_pkg::STEP_W-1:0]      idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q  <= gps_pkg::action_e'(action_i);
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pass_q <= passable_i;
      gx_q   <= goal_x_i;
      gy_q   <= goal_y_i;
      idx_q  <= step_index_i;
    end
  end

  // cost registers
  logic [gps_pkg::COST_W-1:0] straight_q, diag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      straight_q <= gps_pkg::STRAIGHT_COST_RST;
      diag_q     <= gps_pkg::DIAGONAL_COST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gps_pkg::REG_STRAIGHT: straight_q <= cfg_data_i;
        gps_pkg::REG_DIAGONAL: diag_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic start_ok, goal_ok;
  logic [AW-1:0] start_addr, goal_addr;

  assign start_ok   = (int'(px_q) < GRID_WIDTH) && (int'(py_q) < GRID_HEIGHT);
  assign goal_ok    = (int'(gx_q) < GRID_WIDTH) && (int'(gy_q) < GRID_HEIGHT);
  assign start_addr = {YW'(py_q), XW'(px_q)};
  assign goal_addr  = {YW'(gy_q), XW'(gx_q)};

  // sequencer registers
  logic [AW-1:0] sweep_q, cur_q;
  logic [CW-1:0] head_q, tail_q, k_q, count_q;
  logic [SW-1:0] sc_q, gs_q;
  logic [DW-1:0] dir_q;
  logic [3:0]    sw_q;
  logic          found_q;

  // memory read data
  logic          walk_rdata, seen_rdata;
  logic [SW-1:0] score_rdata;
  logic [DW-1:0] parent_rdata;
  logic [AW-1:0] q_rdata, path_rdata;

  // neighbor of the current cell
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [XW:0]   dx_e, nx, pdx_e, prx;
  logic [YW:0]   dy_e, ny, pdy_e, pry;
  logic          n_ok, prev_ok, probe_skip;
  logic [AW-1:0] n_addr, prev_addr;

  assign cx     = cur_q[XW-1:0];
  assign cy     = cur_q[AW-1:XW];
  assign dx_e   = (XW+1)'(gps_pkg::move_dx(dir_q));
  assign dy_e   = (YW+1)'(gps_pkg::move_dy(dir_q));
  assign nx     = {1'b0, cx} + dx_e;
  assign ny     = {1'b0, cy} + dy_e;
  assign n_ok   = (nx < (XW+1)'(GRID_WIDTH)) && (ny < (YW+1)'(GRID_HEIGHT));
  assign n_addr = {ny[YW-1:0], nx[XW-1:0]};

  // diagonals need a passable straight flank
  assign probe_skip = !n_ok ||
                      (dir_q[2] && !(sw_q[gps_pkg::flank_x(dir_q)] ||
                                     sw_q[gps_pkg::flank_y(dir_q)]));

  // step back along the stored parent move
  assign pdx_e     = (XW+1)'(gps_pkg::move_dx(parent_rdata));
  assign pdy_e     = (YW+1)'(gps_pkg::move_dy(parent_rdata));
  assign prx       = {1'b0, cx} - pdx_e;
  assign pry       = {1'b0, cy} - pdy_e;
  assign prev_ok   = (prx < (XW+1)'(GRID_WIDTH)) && (pry < (YW+1)'(GRID_HEIGHT));
  assign prev_addr = {pry[YW-1:0], prx[XW-1:0]};

  // saturating score of the probed move
  logic [gps_pkg::COST_W-1:0] cost;
  logic [SW:0]   sum;
  logic [SW-1:0] new_score;

  assign cost      = dir_q[2] ? diag_q : straight_q;
  assign sum       = {1'b0, sc_q} + (SW+1)'(cost);
  assign new_score = sum[SW] ? gps_pkg::SCORE_MAX : sum[SW-1:0];

  logic new_cell, better, enq, upd, sweeping;

  assign new_cell = walk_rdata && !seen_rdata;
  assign better   = walk_rdata && seen_rdata && (score_rdata > new_score);
  assign enq      = cmd_i.probe_commit && new_cell && (tail_q < CW'(CELLS));
  assign upd      = cmd_i.probe_commit && (new_cell || better);
  assign sweeping = cmd_i.sweep_init || cmd_i.sweep_seen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      found_q <= 1'b0;
      count_q <= '0;
      gs_q    <= '0;
    end else begin
      if (sweeping) sweep_q <= sweep_q + 1'b1;
      if (cmd_i.seed) begin
        head_q <= '0;
        tail_q <= CW'(1);
      end else begin
        if (cmd_i.pop) head_q <= head_q + 1'b1;
        if (enq)       tail_q <= tail_q + 1'b1;
      end
      if (cmd_i.search_init) begin
        found_q <= 1'b0;
        count_q <= '0;
        gs_q    <= '0;
      end else if (cmd_i.trace_ok) begin
        found_q <= 1'b1;
        count_q <= k_q;
        gs_q    <= score_rdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_take) begin
      cur_q <= q_rdata;
      k_q   <= '0;
    end else if (cmd_i.trace_step) begin
      cur_q <= prev_addr;
      k_q   <= k_q + 1'b1;
    end
    if (cmd_i.score_take) begin
      sc_q  <= score_rdata;
      dir_q <= '0;
    end else if ((cmd_i.probe_issue && probe_skip) || cmd_i.probe_commit) begin
      dir_q <= dir_q + 1'b1;
    end
    // cache straight neighbor passability for the diagonal checks
    if (cmd_i.probe_issue && probe_skip && !dir_q[2]) sw_q[dir_q[1:0]] <= 1'b0;
    if (cmd_i.probe_commit && !dir_q[2])              sw_q[dir_q[1:0]] <= walk_rdata;
  end

  gps_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_walk (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sweep_init || (cmd_i.load_write && start_ok)),
    .waddr_i (cmd_i.sweep_init ? sweep_q : start_addr),
    .wdata_i (!cmd_i.sweep_init && pass_q),
    .re_i    (cmd_i.probe_issue),
    .raddr_i (n_addr),
    .rdata_o (walk_rdata)
  );

  gps_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_seen (
    .clk_i   (clk_i),
    .we_i    (sweeping || cmd_i.seed || (cmd_i.probe_commit && new_cell)),
    .waddr_i (sweeping ? sweep_q : (cmd_i.seed ? start_addr : n_addr)),
    .wdata_i (!sweeping),
    .re_i    (cmd_i.probe_issue),
    .raddr_i (n_addr),
    .rdata_o (seen_rdata)
  );

  gps_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_score (
    .clk_i   (clk_i),
    .we_i    (cmd_i.seed || upd),
    .waddr_i (cmd_i.seed ? start_addr : n_addr),
    .wdata_i (cmd_i.seed ? '0 : new_score),
    .re_i    (cmd_i.cur_take || cmd_i.probe_issue),
    .raddr_i (cmd_i.cur_take ? q_rdata : n_addr),
    .rdata_o (score_rdata)
  );

  gps_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_parent (
    .clk_i   (clk_i),
    .we_i    (cmd_i.seed || upd),
    .waddr_i (cmd_i.seed ? start_addr : n_addr),
    .wdata_i (cmd_i.seed ? '0 : dir_q),
    .re_i    (cmd_i.trace_issue),
    .raddr_i (cur_q),
    .rdata_o (parent_rdata)
  );

  gps_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (cmd_i.seed || enq),
    .waddr_i (cmd_i.seed ? '0 : tail_q[AW-1:0]),
    .wdata_i (cmd_i.seed ? start_addr : n_addr),
    .re_i    (cmd_i.pop),
    .raddr_i (head_q[AW-1:0]),
    .rdata_o (q_rdata)
  );

  gps_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_path (
    .clk_i   (clk_i),
    .we_i    (cmd_i.trace_issue),
    .waddr_i (k_q[AW-1:0]),
    .wdata_i (cur_q),
    .re_i    (cmd_i.read_issue),
    .raddr_i (AW'(idx_q)),
    .rdata_o (path_rdata)
  );

  logic read_hit, step_hit, out_valid_q;

  assign read_hit = (32'(idx_q) < 32'(count_q));
  assign step_hit = (act_q == gps_pkg::ACT_READ) && read_hit;

  assign st_o.action     = act_q;
  assign st_o.ends_ok    = start_ok && goal_ok;
  assign st_o.read_hit   = read_hit;
  assign st_o.sweep_last = &sweep_q;
  assign st_o.q_empty    = (head_q == tail_q);
  assign st_o.cur_goal   = (q_rdata == goal_addr);
  assign st_o.probe_skip = probe_skip;
  assign st_o.dir_last   = (dir_q == DW'(7));
  assign st_o.at_start   = (cur_q == start_addr);
  assign st_o.k_full     = (k_q == CW'(CELLS));
  assign st_o.parent_bad = !prev_ok;
  assign st_o.out_free   = !out_valid_q || out_ready_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_o       <= found_q;
      path_length_o <= gps_pkg::LEN_W'(count_q);
      goal_score_o  <= gs_q;
      step_valid_o  <= step_hit;
      step_x_o      <= step_hit ? gps_pkg::COORD_W'(path_rdata[XW-1:0]) : '0;
      step_y_o      <= step_hit ? gps_pkg::COORD_W'(path_rdata[AW-1:XW]) : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/grid_path_search.sv
// top level of the grid path search block
`timescale 1ns / 1ps
// Breadth-first path search on an 8-connected grid of GRID_WIDTH x GRID_HEIGHT cells. Every
// input transfer gives exactly one result transfer. After reset the block sweeps its map and
// visited memories before it takes the first input. A search sweeps the visited memory once,
// then for each dequeued cell probes its neighbors one at a time, skipping those off the grid
// and diagonals without a passable straight flank, and once the goal is dequeued walks back
// along the stored parent moves to the start. The probe loop is set by the single read port
// of each cell memory. The user must write costs through the configuration port only while
// the block is idle; the block itself does not enforce this.
module grid_path_search #(
  parameter int GRID_WIDTH  = gps_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gps_pkg::GRID_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gps_pkg::ACT_W-1:0]     action_i,
  input  logic [gps_pkg::COORD_W-1:0]   pos_x_i,
  input  logic [gps_pkg::COORD_W-1:0]   pos_y_i,
  input  logic                          passable_i,
  input  logic [gps_pkg::COORD_W-1:0]   goal_x_i,
  input  logic [gps_pkg::COORD_W-1:0]   goal_y_i,
  input  logic [gps_pkg::STEP_W-1:0]    step_index_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [gps_pkg::LEN_W-1:0]     path_length_o,
  output logic [gps_pkg::SCORE_W-1:0]   goal_score_o,
  output logic                          step_valid_o,
  output logic [gps_pkg::COORD_W-1:0]   step_x_o,
  output logic [gps_pkg::COORD_W-1:0]   step_y_o,
  // cost register writes
  input  logic                          cfg_we_i,
  input  logic [gps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gps_pkg::COST_W-1:0]    cfg_data_i
);

  // command and status between sequencer and datapath
  gps_pkg::cmd_t    cmd;
  gps_pkg::status_t st;

  // sequencer: one item at a time, result transfer waits only on the output register
  gps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath: map, visited, score, parent, queue and path memories
  gps_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .action_i      (action_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .passable_i    (passable_i),
    .goal_x_i      (goal_x_i),
    .goal_y_i      (goal_y_i),
    .step_index_i  (step_index_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .found_o       (found_o),
    .path_length_o (path_length_o),
    .goal_score_o  (goal_score_o),
    .step_valid_o  (step_valid_o),
    .step_x_o      (step_x_o),
    .step_y_o      (step_y_o)
  );

endmodule
